FILE: design/ssd_pkg.sv
// Shared types, register codes and length limits for the sync signature deframer.
package ssd_pkg;

   // Sizing limits of the frame layout
   localparam int MAX_HEAD_BITS = 16;
   localparam int MAX_TAIL_BITS = 16;
   localparam int MAX_BODY_BITS = 32;
   localparam int SIG_BITS      = 16;
   localparam int WORD_BITS     = 32;
   localparam int WINDOW_BITS   = 64;

   // Effective caps on the programmed lengths
   localparam logic [4:0] HEAD_LEN_CAP =
      5'((MAX_HEAD_BITS < SIG_BITS) ? MAX_HEAD_BITS : SIG_BITS);
   localparam logic [4:0] TAIL_LEN_CAP =
      5'((MAX_TAIL_BITS < SIG_BITS) ? MAX_TAIL_BITS : SIG_BITS);
   localparam logic [5:0] BODY_LEN_CAP =
      6'((MAX_BODY_BITS < WORD_BITS) ? MAX_BODY_BITS : WORD_BITS);

   // Register reset values
   localparam logic [5:0] BODY_LEN_RESET = 6'd8;

   // Register indexes on the csr port
   typedef enum logic [2:0] {
      CSR_HEAD_PATTERN = 3'd0,
      CSR_HEAD_LENGTH  = 3'd1,
      CSR_TAIL_PATTERN = 3'd2,
      CSR_TAIL_LENGTH  = 3'd3,
      CSR_BODY_LENGTH  = 3'd4
   } csr_index_type;

   // Clamped frame layout handed from the front to the engine
   typedef struct packed {
      logic [15:0] head_pattern;
      logic [15:0] tail_pattern;
      logic [4:0]  head_len;
      logic [4:0]  tail_len;
      logic [5:0]  body_len;
      logic [6:0]  pkt_len;
   } frame_cfg_type;

   // Request queue to engine handoff
   typedef struct packed {
      logic valid;
      logic in_bit;
   } bit_req_type;

endpackage

FILE: design/ssd_front.sv
// Front end: csr registers with length clamping, and the request bit queue.
module ssd_front (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  push,
   output logic                  full,
   input  logic                  req_in_bit,
   // csr side
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   // to engine
   output ssd_pkg::bit_req_type  deq,
   input  logic                  deq_take,
   output ssd_pkg::frame_cfg_type cfg
);

   logic [15:0] head_pattern_ff, head_pattern_in;
   logic [4:0]  head_len_ff, head_len_in;
   logic [15:0] tail_pattern_ff, tail_pattern_in;
   logic [4:0]  tail_len_ff, tail_len_in;
   logic [5:0]  body_len_ff, body_len_in;

   logic [1:0]  slot_ff, slot_in;
   logic [1:0]  count_ff, count_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        enq;

   logic [4:0]  head_len;
   logic [4:0]  tail_len;
   logic [5:0]  body_len;

   assign csr_ready = 1'b1;

   // csr write decode
   always_comb begin
      head_pattern_in = head_pattern_ff;
      head_len_in     = head_len_ff;
      tail_pattern_in = tail_pattern_ff;
      tail_len_in     = tail_len_ff;
      body_len_in     = body_len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ssd_pkg::CSR_HEAD_PATTERN: head_pattern_in = csr_wdata;
            ssd_pkg::CSR_HEAD_LENGTH:  head_len_in     = csr_wdata[4:0];
            ssd_pkg::CSR_TAIL_PATTERN: tail_pattern_in = csr_wdata;
            ssd_pkg::CSR_TAIL_LENGTH:  tail_len_in     = csr_wdata[4:0];
            ssd_pkg::CSR_BODY_LENGTH:  body_len_in     = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_pattern_ff <= '0;
         head_len_ff     <= '0;
         tail_pattern_ff <= '0;
         tail_len_ff     <= '0;
         body_len_ff     <= ssd_pkg::BODY_LEN_RESET;
      end else begin
         head_pattern_ff <= head_pattern_in;
         head_len_ff     <= head_len_in;
         tail_pattern_ff <= tail_pattern_in;
         tail_len_ff     <= tail_len_in;
         body_len_ff     <= body_len_in;
      end
   end

   // length clamping: zero body is one bit, all lengths capped
   always_comb begin
      head_len = (head_len_ff > ssd_pkg::HEAD_LEN_CAP) ? ssd_pkg::HEAD_LEN_CAP : head_len_ff;
      tail_len = (tail_len_ff > ssd_pkg::TAIL_LEN_CAP) ? ssd_pkg::TAIL_LEN_CAP : tail_len_ff;
      if (body_len_ff == 6'd0) begin
         body_len = 6'd1;
      end else if (body_len_ff > ssd_pkg::BODY_LEN_CAP) begin
         body_len = ssd_pkg::BODY_LEN_CAP;
      end else begin
         body_len = body_len_ff;
      end
      cfg.head_pattern = head_pattern_ff;
      cfg.tail_pattern = tail_pattern_ff;
      cfg.head_len     = head_len;
      cfg.tail_len     = tail_len;
      cfg.body_len     = body_len;
      cfg.pkt_len      = {2'b00, head_len} + {2'b00, tail_len} + {1'b0, body_len};
   end

   // two-entry request queue
   assign full       = (count_ff == 2'd2);
   assign enq        = push && !full;
   assign deq.valid  = (count_ff != 2'd0);
   assign deq.in_bit = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         slot_in[wr_ptr_ff] = req_in_bit;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (deq_take && deq.valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (enq && !(deq_take && deq.valid)) begin
         count_in = count_ff + 2'd1;
      end else if (!enq && deq_take && deq.valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

`ifndef SYNTHESIS
   // queue occupancy never passes its depth
   a_req_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("request queue overflow");
`endif

endmodule

FILE: design/ssd_engine.sv
// Back end: sliding bit window, head/tail signature compare and body extraction.
module ssd_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  ssd_pkg::bit_req_type   deq,
   output logic                   deq_take,
   input  ssd_pkg::frame_cfg_type cfg,
   input  logic                   rsp_room,
   output logic                   rsp_push,
   output logic [31:0]            rsp_word
);

   logic [63:0] win_ff, win_in;
   logic [6:0]  fill_ff, fill_in;

   logic [63:0] win_new;
   logic [6:0]  fill_new;
   logic [15:0] head_mask;
   logic [15:0] tail_mask;
   logic [31:0] body_mask;
   logic [15:0] tail_seg;
   logic [31:0] body_seg;
   logic [6:0]  tail_pos;
   logic        enough;
   logic        head_ok;
   logic        tail_ok;
   logic        match;

   assign deq_take = deq.valid && rsp_room;

   // masks for the active bit counts
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         head_mask[i] = (5'(i) < cfg.head_len);
         tail_mask[i] = (5'(i) < cfg.tail_len);
      end
      for (int i = 0; i < 32; i++) begin
         body_mask[i] = (6'(i) < cfg.body_len);
      end
   end

   // append the new bit, dropping the oldest when the window is full
   always_comb begin
      if (fill_ff[6]) begin
         win_new  = {deq.in_bit, win_ff[63:1]};
         fill_new = fill_ff;
      end else begin
         win_new  = win_ff | ({63'd0, deq.in_bit} << fill_ff[5:0]);
         fill_new = fill_ff + 7'd1;
      end
   end

   // signature compare on the oldest packet-length bits
   always_comb begin
      tail_pos = {2'b00, cfg.head_len} + {1'b0, cfg.body_len};
      tail_seg = 16'(win_new >> tail_pos);
      body_seg = 32'(win_new >> cfg.head_len) & body_mask;
      enough   = (fill_new >= cfg.pkt_len);
      head_ok  = ((win_new[15:0] ^ cfg.head_pattern) & head_mask) == 16'd0;
      tail_ok  = ((tail_seg ^ cfg.tail_pattern) & tail_mask) == 16'd0;
      match    = enough && head_ok && tail_ok;
   end

   // window update: remove the packet on a match, else slide by one once a packet's worth of bits is held
   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (deq_take) begin
         if (match) begin
            win_in  = win_new >> cfg.pkt_len;
            fill_in = fill_new - cfg.pkt_len;
         end else if (enough) begin
            win_in  = win_new >> 1;
            fill_in = fill_new - 7'd1;
         end else begin
            win_in  = win_new;
            fill_in = fill_new;
         end
      end
   end

   assign rsp_push = deq_take && match;
   assign rsp_word = body_seg;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         fill_ff <= '0;
      end else begin
         win_ff  <= win_in;
         fill_ff <= fill_in;
      end
   end

`ifndef SYNTHESIS
   // fill count stays within the window
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'd64)
      else $error("window fill out of range");

   // bits beyond the fill count are kept clear
   a_window_clean: assert property (@(posedge clock) disable iff (reset)
      (win_ff >> fill_ff) == 64'd0)
      else $error("stale bits above window fill");

   // a result is only produced when the result queue has room
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_room)
      else $error("result pushed without room");
`endif

endmodule

FILE: design/ssd_rsp_queue.sv
// Two-entry result queue between the window engine and the result port.
module ssd_rsp_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        enq,
   input  logic [31:0] enq_word,
   output logic        room,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_body_word
);

   logic [31:0] slot_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        deq;

   assign room          = (count_ff != 2'd2);
   assign empty         = (count_ff == 2'd0);
   assign deq           = pop && !empty;
   assign rsp_body_word = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !deq) begin
         count_in = count_ff + 2'd1;
      end else if (!enq && deq) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= enq_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

`ifndef SYNTHESIS
   // occupancy bounded by the depth
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue overflow");
`endif

endmodule

FILE: design/sync_signature_deframer_core.sv
// Top level of the sync signature deframer: front, window engine and result queue.
//
//  channel   handshake              payload
//  request   push / full            req_in_bit      (1 bit)
//  response  empty / pop            rsp_body_word   (32 bits)
//  csr       csr_valid / csr_ready  csr_index (3), csr_wdata (16)
//
// One bit per cycle is accepted and processed while the result queue has room;
// the window compare is done in the same cycle the engine takes the bit, and a
// result is registered in the result queue before it is on the result ports.
// The loop through the 64-bit window register sets the rate. Reset clears the
// window, queues and registers (body length 8).
// A full result queue stalls the engine; the two-entry request queue then
// fills and raises full. csr_ready is always high.
module sync_signature_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_in_bit,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_body_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ssd_pkg::bit_req_type   deq;
   ssd_pkg::frame_cfg_type cfg;
   logic                   deq_take;
   logic                   rsp_room;
   logic                   rsp_push;
   logic [31:0]            rsp_word;

   ssd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_in_bit (req_in_bit),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .deq        (deq),
      .deq_take   (deq_take),
      .cfg        (cfg)
   );

   ssd_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .deq      (deq),
      .deq_take (deq_take),
      .cfg      (cfg),
      .rsp_room (rsp_room),
      .rsp_push (rsp_push),
      .rsp_word (rsp_word)
   );

   ssd_rsp_queue u_rsp_queue (
      .clock         (clock),
      .reset         (reset),
      .enq           (rsp_push),
      .enq_word      (rsp_word),
      .room          (rsp_room),
      .empty         (empty),
      .pop           (pop),
      .rsp_body_word (rsp_body_word)
   );

endmodule
